FILE: hdl/gf_aes_pkg.sv
// gf_aes_pkg: opcode type, field constants and GF(2^8) helper functions
// for the AES byte arithmetic unit; no dependencies
package gf_aes_pkg;

    typedef enum logic [1:0] {
        OP_MUL      = 2'd0,
        OP_SBOX     = 2'd1,
        OP_INV_SBOX = 2'd2,
        OP_XTIME    = 2'd3
    } opcode_t;

    typedef logic [7:0] byte_t;

    // low byte of the field polynomial x^8 + x^4 + x^3 + x + 1
    localparam byte_t REDUCE_POLY = 8'h1B;
    localparam byte_t AFFINE_FWD  = 8'h63;
    localparam byte_t AFFINE_INV  = 8'h05;

    // reduce a 15-bit carry-less product modulo 0x11B
    function automatic byte_t gf_reduce(input logic [14:0] p);
        logic [14:0] r;
        r = p;
        for (int i = 14; i >= 8; i--)
        begin
            if (r[i])
            begin
                r[i -: 9] = r[i -: 9] ^ {1'b1, REDUCE_POLY};
            end
        end
        return r[7:0];
    endfunction

    function automatic byte_t gf_mul(input byte_t a, input byte_t b);
        logic [14:0] p;
        p = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i])
            begin
                p = p ^ ({7'd0, a} << i);
            end
        end
        return gf_reduce(p);
    endfunction

    // squaring is linear: spread the bits to even positions, then reduce
    function automatic byte_t gf_sq(input byte_t a);
        logic [14:0] p;
        p = '0;
        for (int i = 0; i < 8; i++)
        begin
            p[2 * i] = a[i];
        end
        return gf_reduce(p);
    endfunction

    // a^(2^k) by k successive squarings, k at most 7
    function automatic byte_t gf_pow2k(input byte_t a, input int k);
        byte_t r;
        r = a;
        for (int i = 0; i < 7; i++)
        begin
            if (i < k)
            begin
                r = gf_sq(r);
            end
        end
        return r;
    endfunction

    function automatic byte_t xtime(input byte_t a);
        return {a[6:0], 1'b0} ^ (a[7] ? REDUCE_POLY : 8'h00);
    endfunction

    function automatic byte_t rotl(input byte_t x, input int s);
        return byte_t'((x << s) | (x >> (8 - s)));
    endfunction

    function automatic byte_t affine_fwd(input byte_t b);
        return b ^ rotl(b, 1) ^ rotl(b, 2) ^ rotl(b, 3) ^ rotl(b, 4) ^ AFFINE_FWD;
    endfunction

    function automatic byte_t affine_inv(input byte_t u);
        return rotl(u, 1) ^ rotl(u, 3) ^ rotl(u, 6) ^ AFFINE_INV;
    endfunction

endpackage

FILE: hdl/gf256_aes_arith_unit_top.sv
// gf256_aes_arith_unit_top: pipelined AES GF(2^8) byte unit
// depends on gf_aes_pkg (opcode type, field helper functions)
//
// One byte result per accepted command, one command per cycle. busy is
// always low, so a command is taken whenever start is high. The result
// appears on result_byte with done high for exactly one cycle, once the
// command has passed every stage of the pipe; the receiver cannot stall
// the unit and results leave in command order. The pipe is shaped by
// the inversion a^254, split as a three-level tree of field multiplies:
// stage 1 registers the operand (inverse affine applied for the inverse
// S-box), stage 2 forms x^6, x^24, x^96 and x^128 (or the product a*b, or
// xtime a), stage 3 forms x^30 and x^224, and the output stage multiplies
// them, applies the forward affine map for the S-box and picks the result.
// The inverse of zero comes out as zero, so sbox(0) is 0x63.
module gf256_aes_arith_unit_top
    import gf_aes_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] opcode,
    input  logic [7:0] operand_a,
    input  logic [7:0] operand_b,
    output logic       done,
    output logic [7:0] result_byte
);

    // pipe never holds off, so the command side is always open
    assign busy = 1'b0;

    // stage 1: operand capture
    logic    s1_valid_reg, s1_valid_next;
    opcode_t s1_op_reg,    s1_op_next;
    byte_t   s1_x_reg,     s1_x_next;
    byte_t   s1_b_reg,     s1_b_next;

    // stage 2: partial products of the power chain
    logic    s2_valid_reg, s2_valid_next;
    opcode_t s2_op_reg,    s2_op_next;
    byte_t   s2_m1_reg,    s2_m1_next;
    byte_t   s2_m2_reg,    s2_m2_next;
    byte_t   s2_m3_reg,    s2_m3_next;
    byte_t   s2_x128_reg,  s2_x128_next;

    // stage 3: x^30 and x^224
    logic    s3_valid_reg, s3_valid_next;
    opcode_t s3_op_reg,    s3_op_next;
    byte_t   s3_n1_reg,    s3_n1_next;
    byte_t   s3_n2_reg,    s3_n2_next;

    // output stage
    logic    done_reg,   done_next;
    byte_t   result_reg, result_next;

    byte_t   inv_val;

    // stage 1 next: the inverse S-box starts with the inverse affine map
    always_comb
    begin
        s1_valid_next = start;
        s1_op_next    = opcode_t'(opcode);
        s1_b_next     = operand_b;
        case (opcode_t'(opcode))
            OP_INV_SBOX: s1_x_next = affine_inv(operand_a);
            default:     s1_x_next = operand_a;
        endcase
    end

    // stage 2 next: m1 carries the whole answer for multiply and xtime
    always_comb
    begin
        s2_valid_next = s1_valid_reg;
        s2_op_next    = s1_op_reg;
        s2_m2_next    = gf_mul(gf_pow2k(s1_x_reg, 3), gf_pow2k(s1_x_reg, 4));
        s2_m3_next    = gf_mul(gf_pow2k(s1_x_reg, 5), gf_pow2k(s1_x_reg, 6));
        s2_x128_next  = gf_pow2k(s1_x_reg, 7);
        case (s1_op_reg)
            OP_MUL:   s2_m1_next = gf_mul(s1_x_reg, s1_b_reg);
            OP_XTIME: s2_m1_next = xtime(s1_x_reg);
            default:  s2_m1_next = gf_mul(gf_sq(s1_x_reg), gf_pow2k(s1_x_reg, 2));
        endcase
    end

    // stage 3 next
    always_comb
    begin
        s3_valid_next = s2_valid_reg;
        s3_op_next    = s2_op_reg;
        s3_n2_next    = gf_mul(s2_m3_reg, s2_x128_reg);
        case (s2_op_reg)
            OP_MUL,
            OP_XTIME: s3_n1_next = s2_m1_reg;
            default:  s3_n1_next = gf_mul(s2_m1_reg, s2_m2_reg);
        endcase
    end

    // output stage next: final multiply gives x^254
    always_comb
    begin
        inv_val   = gf_mul(s3_n1_reg, s3_n2_reg);
        done_next = s3_valid_reg;
        case (s3_op_reg)
            OP_SBOX:     result_next = affine_fwd(inv_val);
            OP_INV_SBOX: result_next = inv_val;
            default:     result_next = s3_n1_reg;
        endcase
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
            done_reg     <= done_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        s1_op_reg   <= s1_op_next;
        s1_x_reg    <= s1_x_next;
        s1_b_reg    <= s1_b_next;
        s2_op_reg   <= s2_op_next;
        s2_m1_reg   <= s2_m1_next;
        s2_m2_reg   <= s2_m2_next;
        s2_m3_reg   <= s2_m3_next;
        s2_x128_reg <= s2_x128_next;
        s3_op_reg   <= s3_op_next;
        s3_n1_reg   <= s3_n1_next;
        s3_n2_reg   <= s3_n2_next;
        result_reg  <= result_next;
    end

    assign done        = done_reg;
    assign result_byte = result_reg;

endmodule
